### rtl/cdad_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date add days: shared package
// Types, calendar constants and small calendar functions used by the
// controller, the datapath, the top level and the port checker.
// ----------------------------------------------------------------------------
package cdad_pkg;

    localparam int MONTHS = 12;
    localparam logic [3:0] FEB = 4'd2;
    localparam logic [8:0] YEAR_DAYS = 9'd365;
    localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
    localparam logic [13:0] MIN_YEAR = 14'd1900;

    // Reset date is 1 January 1900, kept as century and year of century.
    localparam logic [3:0] RST_MONTH = 4'd1;
    localparam logic [4:0] RST_DAY = 5'd1;
    localparam logic [13:0] RST_YEAR = 14'd1900;
    localparam logic [7:0] RST_CEN = 8'd19;
    localparam logic [6:0] RST_YOC = 7'd0;

    // Century of a year below 43699 is (year * 5243) >> 19.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W = 27;
    localparam logic [6:0] LAST_YOC = 7'd99;
    localparam logic [6:0] CENTURY = 7'd100;

    localparam logic [4:0] MONTH_DAYS [MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [8:0] CUM_DAYS [MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL,
        OP_SET,
        OP_AINIT,
        OP_YEAR,
        OP_OVER,
        OP_MONTH,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ld_out;
    } t_cmd;

    typedef struct packed {
        logic year_more;
        logic at_max;
        logic month_more;
    } t_sts;

    // The year is divisible by 4 exactly when its year of century is.
    function automatic logic leap_f(input logic [7:0] cen, input logic [6:0] yoc);
        return (yoc != 7'd0) ? (yoc[1:0] == 2'b00) : (cen[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] mlen_f(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (m >= 4'd1 && m <= 4'(MONTHS)) begin
            len = MONTH_DAYS[m - 4'd1];
        end
        if (m == FEB && leap) begin
            len = 5'd29;
        end
        return len;
    endfunction

    function automatic logic [8:0] cum_f(input logic [3:0] m, input logic leap);
        logic [8:0] sum;
        sum = 9'd0;
        if (m >= 4'd1 && m <= 4'(MONTHS)) begin
            sum = CUM_DAYS[m - 4'd1];
        end
        if (m > FEB && leap) begin
            sum = sum + 9'd1;
        end
        return sum;
    endfunction

endpackage

### rtl/cdad_if.sv
// ----------------------------------------------------------------------------
// Calendar date add days: channel interfaces
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface cdad_req_if #(
    parameter int ADD_WIDTH = 16
);
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [3:0]           new_month;
    logic [4:0]           new_day;
    logic [13:0]          new_year;
    logic [ADD_WIDTH-1:0] add_count;

    modport source (
        output valid, req_type, new_month, new_day, new_year, add_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, new_month, new_day, new_year, add_count,
        output ready
    );
endinterface

interface cdad_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [13:0] year_out;
    logic        leap_flag;
    logic [4:0]  month_length;
    logic [8:0]  day_of_year;
    logic [8:0]  days_left;
    logic [1:0]  status;

    modport source (
        output valid, month_out, day_out, year_out, leap_flag, month_length,
               day_of_year, days_left, status,
        input  ready
    );
    modport sink (
        input  valid, month_out, day_out, year_out, leap_flag, month_length,
               day_of_year, days_left, status,
        output ready
    );
endinterface

### rtl/cdad_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date add days: controller
// Sequences a set or advance request through the datapath and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module cdad_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic           i_out_ready,
    input  cdad_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output cdad_pkg::t_cmd o_cmd
);
    import cdad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SMUL,
        S_SCHK,
        S_AINIT,
        S_AYEAR,
        S_AMONTH,
        S_RES
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd.op = OP_IDLE;
        cmd.ld_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op = OP_LOAD;
                    n_state = i_req_type ? S_AINIT : S_SMUL;
                end
            end
            S_SMUL: begin
                cmd.op = OP_MUL;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                cmd.op = OP_SET;
                n_state = S_RES;
            end
            S_AINIT: begin
                cmd.op = OP_AINIT;
                n_state = S_AYEAR;
            end
            S_AYEAR: begin
                if (i_sts.year_more && i_sts.at_max) begin
                    cmd.op = OP_OVER;
                    n_state = S_RES;
                end else if (i_sts.year_more) begin
                    cmd.op = OP_YEAR;
                end else begin
                    n_state = S_AMONTH;
                end
            end
            S_AMONTH: begin
                if (i_sts.month_more) begin
                    cmd.op = OP_MONTH;
                end else begin
                    cmd.op = OP_COMMIT;
                    n_state = S_RES;
                end
            end
            S_RES: begin
                // The result waits here only while the previous one is unclaimed.
                if (!r_out_valid || i_out_ready) begin
                    cmd.ld_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd = cmd;

endmodule

### rtl/cdad_dp.sv
// ----------------------------------------------------------------------------
// Calendar date add days: datapath
// Holds the stored date, the working registers of an advance and the
// result register.
// ----------------------------------------------------------------------------
module cdad_dp #(
    parameter int MAX_YEAR = 9999,
    parameter int ADD_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdad_pkg::t_cmd       i_cmd,
    input  logic [3:0]           i_new_month,
    input  logic [4:0]           i_new_day,
    input  logic [13:0]          i_new_year,
    input  logic [ADD_WIDTH-1:0] i_add_count,
    output cdad_pkg::t_sts       o_sts,
    output logic [3:0]           o_month_out,
    output logic [4:0]           o_day_out,
    output logic [13:0]          o_year_out,
    output logic                 o_leap_flag,
    output logic [4:0]           o_month_length,
    output logic [8:0]           o_day_of_year,
    output logic [8:0]           o_days_left,
    output logic [1:0]           o_status
);
    import cdad_pkg::*;

    // Day count of an advance: day of year plus the request count.
    localparam int TW = ((ADD_WIDTH > 9) ? ADD_WIDTH : 9) + 1;

    // Stored date, with the year also kept as century and year of century.
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [13:0] r_year;
    logic [7:0]  r_cen;
    logic [6:0]  r_yoc;
    t_status     r_status;

    logic [3:0]           r_req_month;
    logic [4:0]           r_req_day;
    logic [13:0]          r_req_year;
    logic [ADD_WIDTH-1:0] r_req_add;
    logic [PROD_W-1:0]    r_prod;

    logic [TW-1:0] r_total;
    logic [13:0]   r_wyear;
    logic [7:0]    r_wcen;
    logic [6:0]    r_wyoc;
    logic [3:0]    r_wmonth;

    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [13:0] r_o_year;
    logic        r_o_leap;
    logic [4:0]  r_o_mlen;
    logic [8:0]  r_o_doy;
    logic [8:0]  r_o_left;
    logic [1:0]  r_o_status;

    logic       cur_leap;
    logic [4:0] cur_mlen;
    logic [8:0] cur_doy;
    logic [8:0] cur_ylen;
    logic       wk_leap;
    logic [8:0] wk_ylen;
    logic [4:0] wk_mlen;
    logic [7:0] s_cen;
    logic [6:0] s_yoc;
    logic       s_leap;
    logic       s_valid;

    always_comb begin
        cur_leap = leap_f(r_cen, r_yoc);
        cur_mlen = mlen_f(r_month, cur_leap);
        cur_doy = cum_f(r_month, cur_leap) + 9'(r_day);
        cur_ylen = cur_leap ? LEAP_YEAR_DAYS : YEAR_DAYS;

        wk_leap = leap_f(r_wcen, r_wyoc);
        wk_ylen = wk_leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
        wk_mlen = mlen_f(r_wmonth, wk_leap);

        s_cen = r_prod[RECIP_SHIFT +: 8];
        s_yoc = 7'(r_req_year - 14'(s_cen) * 14'(CENTURY));
        s_leap = leap_f(s_cen, s_yoc);
        s_valid = (r_req_month >= 4'd1) && (r_req_month <= 4'(MONTHS))
               && (r_req_year >= MIN_YEAR) && (r_req_year <= 14'(MAX_YEAR))
               && (r_req_day >= 5'd1) && (r_req_day <= mlen_f(r_req_month, s_leap));

        o_sts.year_more = (r_total > TW'(wk_ylen));
        o_sts.at_max = (r_wyear == 14'(MAX_YEAR));
        o_sts.month_more = (r_wmonth < 4'(MONTHS)) && (r_total > TW'(wk_mlen));
    end

    // Stored date and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month <= RST_MONTH;
            r_day <= RST_DAY;
            r_year <= RST_YEAR;
            r_cen <= RST_CEN;
            r_yoc <= RST_YOC;
            r_status <= ST_OK;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: r_status <= ST_OK;
                OP_SET: begin
                    if (s_valid) begin
                        r_month <= r_req_month;
                        r_day <= r_req_day;
                        r_year <= r_req_year;
                        r_cen <= s_cen;
                        r_yoc <= s_yoc;
                    end else begin
                        r_status <= ST_INVALID;
                    end
                end
                OP_OVER: r_status <= ST_OVERFLOW;
                OP_COMMIT: begin
                    r_month <= r_wmonth;
                    r_day <= 5'(r_total);
                    r_year <= r_wyear;
                    r_cen <= r_wcen;
                    r_yoc <= r_wyoc;
                end
                OP_IDLE, OP_MUL, OP_AINIT, OP_YEAR, OP_MONTH: ;
                default: ;
            endcase
        end
    end

    // Request latch and working registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_req_month <= i_new_month;
                r_req_day <= i_new_day;
                r_req_year <= i_new_year;
                r_req_add <= i_add_count;
            end
            OP_MUL: r_prod <= PROD_W'(r_req_year) * PROD_W'(RECIP_100);
            OP_AINIT: begin
                r_total <= TW'(cur_doy) + TW'(r_req_add);
                r_wyear <= r_year;
                r_wcen <= r_cen;
                r_wyoc <= r_yoc;
                r_wmonth <= 4'd1;
            end
            OP_YEAR: begin
                r_total <= r_total - TW'(wk_ylen);
                r_wyear <= r_wyear + 14'd1;
                if (r_wyoc == LAST_YOC) begin
                    r_wyoc <= 7'd0;
                    r_wcen <= r_wcen + 8'd1;
                end else begin
                    r_wyoc <= r_wyoc + 7'd1;
                end
            end
            OP_MONTH: begin
                r_total <= r_total - TW'(wk_mlen);
                r_wmonth <= r_wmonth + 4'd1;
            end
            OP_IDLE, OP_SET, OP_OVER, OP_COMMIT: ;
            default: ;
        endcase
    end

    // Result register, loaded from the date after the request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_o_month <= r_month;
            r_o_day <= r_day;
            r_o_year <= r_year;
            r_o_leap <= cur_leap;
            r_o_mlen <= cur_mlen;
            r_o_doy <= cur_doy;
            r_o_left <= cur_ylen - cur_doy;
            r_o_status <= r_status;
        end
    end

    assign o_month_out = r_o_month;
    assign o_day_out = r_o_day;
    assign o_year_out = r_o_year;
    assign o_leap_flag = r_o_leap;
    assign o_month_length = r_o_mlen;
    assign o_day_of_year = r_o_doy;
    assign o_days_left = r_o_left;
    assign o_status = r_o_status;

endmodule

### rtl/calendar_date_add_days.sv
// ----------------------------------------------------------------------------
// Calendar date add days: top level
// Gregorian date keeper that sets a date or advances it by a day count.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one response beat describing the stored
// date afterwards. A set computes the century, then checks and stores the
// date. An advance first crosses Y years (about 180 at most for a 16-bit
// count), one year per cycle in the datapath's rollover loop, and then
// takes at most 11 month steps. A response waiting in the output register
// does not block the next request beat; only a second finished result
// waits for it to drain.
module calendar_date_add_days #(
    parameter int MAX_YEAR = 9999,
    parameter int ADD_WIDTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    cdad_req_if.sink   i_req,
    cdad_rsp_if.source o_rsp
);
    import cdad_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    cdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    cdad_dp #(
        .MAX_YEAR  (MAX_YEAR),
        .ADD_WIDTH (ADD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_new_month    (i_req.new_month),
        .i_new_day      (i_req.new_day),
        .i_new_year     (i_req.new_year),
        .i_add_count    (i_req.add_count),
        .o_sts          (sts),
        .o_month_out    (o_rsp.month_out),
        .o_day_out      (o_rsp.day_out),
        .o_year_out     (o_rsp.year_out),
        .o_leap_flag    (o_rsp.leap_flag),
        .o_month_length (o_rsp.month_length),
        .o_day_of_year  (o_rsp.day_of_year),
        .o_days_left    (o_rsp.days_left),
        .o_status       (o_rsp.status)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

### rtl/cdad_chk.sv
// ----------------------------------------------------------------------------
// Calendar date add days: port checker
// Checks response consistency and handshake behavior seen at the ports.
// ----------------------------------------------------------------------------
module cdad_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_month_out,
    input logic [4:0]  i_day_out,
    input logic        i_leap_flag,
    input logic [4:0]  i_month_length,
    input logic [8:0]  i_day_of_year,
    input logic [8:0]  i_days_left
);
    import cdad_pkg::*;

    // A waiting response beat holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_day_of_year)
            && $stable(i_month_out) && $stable(i_day_out))
        else $error("response beat changed while stalled");

    // Day of year and days left always add up to the year length.
    a_year_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (10'(i_day_of_year) + 10'(i_days_left)
            == 10'(YEAR_DAYS) + 10'(i_leap_flag)))
        else $error("day of year and days left disagree with year length");

    // The reported date is always a real date.
    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_month_out >= 4'd1) && (i_month_out <= 4'(MONTHS))
            && (i_day_out >= 5'd1) && (i_day_out <= i_month_length))
        else $error("response holds an impossible date");

    // Requests are worked one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while another is in progress");

endmodule

bind calendar_date_add_days cdad_chk u_cdad_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_month_out    (o_rsp.month_out),
    .i_day_out      (o_rsp.day_out),
    .i_leap_flag    (o_rsp.leap_flag),
    .i_month_length (o_rsp.month_length),
    .i_day_of_year  (o_rsp.day_of_year),
    .i_days_left    (o_rsp.days_left)
);
